// ===== rtl/cr3gg_pkg.sv =====
// Shared types, widths and constants for the CR3BP gravity-gradient unit.
// No dependencies; every other file in rtl/ imports this package.
package cr3gg_pkg;

  // Field widths
  localparam int POS_W     = 32;
  localparam int GRAD_W    = 48;
  localparam int NUM_GRAD  = 6;
  localparam int D_W       = POS_W + 1;     // offset from a primary
  localparam int MAG_W     = 32;            // |offset| and unit components
  localparam int SQ_W      = 2 * MAG_W;     // squared distance
  localparam int EXP_W     = 5;             // normalize exponent
  localparam int ROOT_W    = 32;
  localparam int RECIP_W   = ROOT_W + 1;    // 2^63 / root can reach 2^32
  localparam int MASS_W    = 32;
  localparam int K_W       = 63;            // m / r^3, Q.36, capped at 2^62
  localparam int T_W       = 63;            // 3 * u_a * u_b / 4, Q.60
  localparam int F_W       = 62;            // |factor|, Q.60
  localparam int MG_W      = 53;            // |contribution|, Q.24
  localparam int CONTRIB_W = MG_W + 1;
  localparam int SUM_W     = CONTRIB_W + 2;

  // Pipeline depths
  localparam int PRE_LAT   = 5;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int RECIP_LAT = RECIP_W;
  localparam int SIDE_LAT  = SQRT_LAT + RECIP_LAT;
  localparam int POST_LAT  = 9;
  localparam int LANE_LAT  = PRE_LAT + SIDE_LAT + POST_LAT;
  localparam int TOTAL_LAT = LANE_LAT + 2;

  // Primaries: x positions in Q3.29, masses in Q0.32
  localparam logic signed [POS_W-1:0] EARTH_X = -32'sd6522982;
  localparam logic signed [POS_W-1:0] MOON_X  = 32'sd530347930;
  localparam logic [MASS_W-1:0] MU_Q32      = 32'd52183853;
  localparam logic [MASS_W-1:0] EARTH_M_Q32 = 32'd4242783443;

  localparam logic [K_W-1:0] K_CAP = K_W'(1) << 62;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << 60;

  localparam logic signed [SUM_W-1:0] ONE_Q24  = SUM_W'(1 << 24);
  localparam logic signed [SUM_W-1:0] GRAD_MAX = (SUM_W'(1) <<< (GRAD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] GRAD_MIN = -(SUM_W'(1) <<< (GRAD_W - 1));

  // Entry order: xx, xy, xz, yy, yz, zz
  localparam logic [1:0] PAIR_A [NUM_GRAD] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [NUM_GRAD] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [NUM_GRAD-1:0] CENTRIFUGAL = 6'b001001;   // xx and yy

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_xx;
    logic signed [GRAD_W-1:0] grad_xy;
    logic signed [GRAD_W-1:0] grad_xz;
    logic signed [GRAD_W-1:0] grad_yy;
    logic signed [GRAD_W-1:0] grad_yz;
    logic signed [GRAD_W-1:0] grad_zz;
    logic                     saturated;
    logic                     singular;
  } grad_t;

  // Per-primary data riding alongside the root and reciprocal pipes
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [EXP_W-1:0]      e;
    logic                  zero;
  } side_t;

  // One primary's contribution to the six entries
  typedef struct packed {
    logic [NUM_GRAD-1:0][CONTRIB_W-1:0] contrib;
    logic                               kcap;
    logic                               zero;
  } lane_t;

endpackage

// ===== rtl/cr3bp_gravity_gradient_unit.sv =====
// Top level of the Earth-Moon CR3BP gravity-gradient unit.
// Depends on cr3gg_pkg and cr3gg_primary (which uses cr3gg_sqrt, cr3gg_recip).
//
// Takes one rotating-frame position word (Q3.29) per cycle and returns the six
// distinct entries of the acceleration-by-position Jacobian block (Q24.24),
// with saturated and singular flags, once the lane results are summed, clamped and registered.
// Earth and Moon terms are computed in two parallel lanes; the depth is set by
// the 32-stage square root and 33-stage reciprocal in each lane. The whole
// pipeline advances together: while a result word sits unread on the output,
// every stage holds and pos_ready is low; otherwise one word enters per cycle.
// No word is taken while rst is high.
module cr3bp_gravity_gradient_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             pos_valid,
  output logic             pos_ready,
  input  cr3gg_pkg::pos_t  pos,
  output logic             grad_valid,
  input  logic             grad_ready,
  output cr3gg_pkg::grad_t grad
);
  import cr3gg_pkg::*;

  logic                          en;
  logic [TOTAL_LAT-1:0]          vld;
  lane_t                         earth, moon;
  logic signed [SUM_W-1:0]       t1_sum [NUM_GRAD];
  logic                          t1_sat, t1_sing;
  logic signed [GRAD_W-1:0]      gv [NUM_GRAD];
  logic                          sat_c;
  grad_t                         grad_next;

  // global advance: output empty or being taken
  assign en         = !grad_valid || grad_ready;
  assign pos_ready  = en && !rst;
  assign grad_valid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], pos_valid};
    end
  end

  cr3gg_primary u_earth (
    .clk    (clk),
    .en     (en),
    .pos    (pos),
    .prim_x (EARTH_X),
    .mass   (EARTH_M_Q32),
    .res    (earth)
  );

  cr3gg_primary u_moon (
    .clk    (clk),
    .en     (en),
    .pos    (pos),
    .prim_x (MOON_X),
    .mass   (MU_Q32),
    .res    (moon)
  );

  // combine both primaries plus centrifugal term
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) begin
        t1_sum[i] <= SUM_W'($signed(earth.contrib[i])) + SUM_W'($signed(moon.contrib[i]))
                     + (CENTRIFUGAL[i] ? ONE_Q24 : SUM_W'(0));
      end
      t1_sat  <= earth.kcap | moon.kcap;
      t1_sing <= earth.zero | moon.zero;
    end
  end

  // clamp to Q24.24 range; singular position forces zeros
  always_comb begin
    sat_c = t1_sat;
    for (int i = 0; i < NUM_GRAD; i++) begin
      if (t1_sum[i] > GRAD_MAX) begin
        gv[i] = GRAD_MAX[GRAD_W-1:0];
        sat_c = 1'b1;
      end else if (t1_sum[i] < GRAD_MIN) begin
        gv[i] = GRAD_MIN[GRAD_W-1:0];
        sat_c = 1'b1;
      end else begin
        gv[i] = t1_sum[i][GRAD_W-1:0];
      end
    end
    grad_next.grad_xx   = gv[0];
    grad_next.grad_xy   = gv[1];
    grad_next.grad_xz   = gv[2];
    grad_next.grad_yy   = gv[3];
    grad_next.grad_yz   = gv[4];
    grad_next.grad_zz   = gv[5];
    grad_next.saturated = sat_c;
    grad_next.singular  = 1'b0;
    if (t1_sing) begin
      grad_next.grad_xx   = '0;
      grad_next.grad_xy   = '0;
      grad_next.grad_xz   = '0;
      grad_next.grad_yy   = '0;
      grad_next.grad_yz   = '0;
      grad_next.grad_zz   = '0;
      grad_next.saturated = 1'b0;
      grad_next.singular  = 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (en) begin
      grad <= grad_next;
    end
  end

endmodule

// ===== rtl/cr3gg_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on cr3gg_pkg.
module cr3gg_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cr3gg_pkg::SQ_W-1:0]    rad,
  output logic [cr3gg_pkg::ROOT_W-1:0]  root
);
  import cr3gg_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [SQRT_LAT-1];
  logic [SQ_W-1:0]   rad_r  [SQRT_LAT-1];
  logic [ROOT_W-1:0] root_r [SQRT_LAT];

  assign root = root_r[SQRT_LAT-1];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [REM_W-1:0]  rem_p, rem_n;
    logic [SQ_W-1:0]   rad_p;
    logic [ROOT_W-1:0] root_p, root_n;
    logic [REM_W+1:0]  cand, trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign rad_p  = rad;
      assign root_p = '0;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign root_p = root_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cand  = {rem_p, rad_p[SQ_W-1 -: 2]};
      trial = {root_p, 2'b01};
      if (cand >= trial) begin
        rem_n  = REM_W'(cand - trial);
        root_n = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n  = REM_W'(cand);
        root_n = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_n;
      end
    end

    if (k < SQRT_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_n;
          rad_r[k] <= rad_p << 2;
        end
      end
    end
  end

endmodule

// ===== rtl/cr3gg_recip.sv =====
// Pipelined reciprocal mantissa floor(2^63 / q) for q in [2^31, 2^32),
// one quotient bit per stage. Depends on cr3gg_pkg.
module cr3gg_recip (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cr3gg_pkg::ROOT_W-1:0]  q,
  output logic [cr3gg_pkg::RECIP_W-1:0] w
);
  import cr3gg_pkg::*;

  logic [ROOT_W-1:0]  rem_r [RECIP_LAT-1];
  logic [ROOT_W-1:0]  div_r [RECIP_LAT-1];
  logic [RECIP_W-1:0] quo_r [RECIP_LAT];

  assign w = quo_r[RECIP_LAT-1];

  for (genvar k = 0; k < RECIP_LAT; k++) begin : g_stage
    logic [ROOT_W-1:0]  rem_p, rem_n, div_p;
    logic [RECIP_W-1:0] quo_p, quo_n;
    logic [ROOT_W:0]    r;

    if (k == 0) begin : g_first
      assign rem_p = ROOT_W'(1) << (ROOT_W - 2);   // top of 2^63, pre-shift
      assign div_p = q;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign div_p = div_r[k-1];
      assign quo_p = quo_r[k-1];
    end

    // restoring step: shift, compare, subtract
    always_comb begin
      r = {rem_p, 1'b0};
      if (r >= {1'b0, div_p}) begin
        rem_n = ROOT_W'(r - {1'b0, div_p});
        quo_n = {quo_p[RECIP_W-2:0], 1'b1};
      end else begin
        rem_n = r[ROOT_W-1:0];
        quo_n = {quo_p[RECIP_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_n;
      end
    end

    if (k < RECIP_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_n;
          div_r[k] <= div_p;
        end
      end
    end
  end

endmodule

// ===== rtl/cr3gg_primary.sv =====
// One primary's share of the gravity gradient: offset, distance, root,
// reciprocal, inverse cube and the six tensor terms. Depends on cr3gg_pkg,
// cr3gg_sqrt and cr3gg_recip.
module cr3gg_primary (
  input  logic                               clk,
  input  logic                               en,
  input  cr3gg_pkg::pos_t                    pos,
  input  logic signed [cr3gg_pkg::POS_W-1:0] prim_x,
  input  logic [cr3gg_pkg::MASS_W-1:0]       mass,
  output cr3gg_pkg::lane_t                   res
);
  import cr3gg_pkg::*;

  // ---------------- distance stages ----------------
  logic signed [D_W-1:0] p1_d [3];
  logic [2:0][MAG_W-1:0] p2_mag, p3_mag, p4_mag, p5_mag;
  logic [2:0]            p2_neg, p3_neg, p4_neg, p5_neg;
  logic [SQ_W-1:0]       p3_sq [3];
  logic [SQ_W-1:0]       p4_s, p5_n, n_c;
  logic [EXP_W-1:0]      p5_e, e_c;
  logic                  p5_zero;

  // offsets from the primary
  always_ff @(posedge clk) begin
    if (en) begin
      p1_d[0] <= D_W'(pos.pos_x) - D_W'(prim_x);
      p1_d[1] <= D_W'(pos.pos_y);
      p1_d[2] <= D_W'(pos.pos_z);
    end
  end

  // magnitude and sign, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_neg[i] <= p1_d[i][D_W-1];
        p2_mag[i] <= p1_d[i][D_W-1] ? MAG_W'(-p1_d[i]) : MAG_W'(p1_d[i]);
        p3_sq[i]  <= SQ_W'(p2_mag[i]) * SQ_W'(p2_mag[i]);
      end
      p3_mag <= p2_mag;
      p3_neg <= p2_neg;
      p4_s   <= p3_sq[0] + p3_sq[1] + p3_sq[2];
      p4_mag <= p3_mag;
      p4_neg <= p3_neg;
    end
  end

  // normalize by 4^e so the radicand has its top bit pair nonzero
  always_comb begin
    e_c = '0;
    for (int j = 0; j < SQ_W / 2; j++) begin
      if (p4_s[2*j +: 2] != 2'b00) e_c = EXP_W'(SQ_W / 2 - 1 - j);
    end
    n_c = p4_s << {e_c, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_n    <= n_c;
      p5_e    <= e_c;
      p5_zero <= (p4_s == '0);
      p5_mag  <= p4_mag;
      p5_neg  <= p4_neg;
    end
  end

  // ---------------- root and reciprocal ----------------
  logic [ROOT_W-1:0]  q;
  logic [RECIP_W-1:0] w;
  side_t              sb [SIDE_LAT];
  side_t              sb_in, sbo;

  cr3gg_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (p5_n),
    .root (q)
  );

  cr3gg_recip u_recip (
    .clk (clk),
    .en  (en),
    .q   (q),
    .w   (w)
  );

  always_comb begin
    sb_in.mag  = p5_mag;
    sb_in.neg  = p5_neg;
    sb_in.e    = p5_e;
    sb_in.zero = p5_zero;
  end

  // side data delay line, matched to root plus reciprocal depth
  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= sb_in;
      for (int i = 1; i < SIDE_LAT; i++) sb[i] <= sb[i-1];
    end
  end

  assign sbo = sb[SIDE_LAT-1];

  // ---------------- inverse cube and tensor terms ----------------
  logic [2*RECIP_W-1:0]   m1_ww, m2_cw;
  logic [MAG_W+RECIP_W-1:0] m1_mw [3];
  logic [RECIP_W-1:0]     m1_w;
  logic [MAG_W-1:0]       m2_u [3];
  logic [RECIP_W+MASS_W-1:0] m3_cm;
  logic [SQ_W-1:0]        m3_uu [NUM_GRAD];
  logic [EXP_W-1:0]       m1_e, m2_e, m3_e;
  logic [2:0]             m1_neg, m2_neg, m3_neg;
  logic                   m1_zero, m2_zero, m3_zero, m4_zero, m5_zero, m6_zero;
  logic                   m7_zero, m8_zero;
  logic [K_W-1:0]         m4_k, m5_k, k_c;
  logic                   m4_cap, m5_cap, m6_cap, m7_cap, m8_cap, cap_c;
  logic [T_W-1:0]         m4_t [NUM_GRAD];
  logic [NUM_GRAD-1:0]    m4_sgn, m5_neg, m6_neg, m7_neg, m8_neg;
  logic [F_W-1:0]         m5_f [NUM_GRAD];
  logic [63:0]            m6_p00 [NUM_GRAD];
  logic [61:0]            m6_p01 [NUM_GRAD];
  logic [62:0]            m6_p10 [NUM_GRAD];
  logic [60:0]            m6_p11 [NUM_GRAD];
  logic [63:0]            m7_lo  [NUM_GRAD];
  logic [64:0]            m7_mid [NUM_GRAD];
  logic [60:0]            m7_hi  [NUM_GRAD];
  logic [124:0]           full_c [NUM_GRAD];
  logic [MG_W-1:0]        m8_mg  [NUM_GRAD];
  logic [RECIP_W-1:0]     c3;
  logic [6:0]             sh;
  logic [95:0]            wide;

  // w^2 and |d|*w products
  always_ff @(posedge clk) begin
    if (en) begin
      m1_ww <= (2*RECIP_W)'(w) * (2*RECIP_W)'(w);
      for (int i = 0; i < 3; i++) begin
        m1_mw[i] <= (MAG_W+RECIP_W)'(sbo.mag[i]) * (MAG_W+RECIP_W)'(w);
      end
      m1_w    <= w;
      m1_e    <= sbo.e;
      m1_neg  <= sbo.neg;
      m1_zero <= sbo.zero;
    end
  end

  // w^3 product, unit components
  always_ff @(posedge clk) begin
    if (en) begin
      m2_cw <= (2*RECIP_W)'(m1_ww[64:32]) * (2*RECIP_W)'(m1_w);
      for (int i = 0; i < 3; i++) begin
        m2_u[i] <= MAG_W'(m1_mw[i] >> (6'd32 - 6'(m1_e)));
      end
      m2_e    <= m1_e;
      m2_neg  <= m1_neg;
      m2_zero <= m1_zero;
    end
  end

  // mass scaling, unit products
  always_ff @(posedge clk) begin
    if (en) begin
      m3_cm <= (RECIP_W+MASS_W)'(m2_cw[64:32]) * (RECIP_W+MASS_W)'(mass);
      for (int i = 0; i < NUM_GRAD; i++) begin
        m3_uu[i] <= SQ_W'(m2_u[PAIR_A[i]]) * SQ_W'(m2_u[PAIR_B[i]]);
      end
      m3_e    <= m2_e;
      m3_neg  <= m2_neg;
      m3_zero <= m2_zero;
    end
  end

  // undo the normalization on m/r^3, capping at 2^62
  always_comb begin
    c3    = m3_cm[64:32];
    sh    = 7'({m3_e, 1'b0}) + 7'(m3_e) - 7'd2;
    wide  = 96'(c3) << sh;
    cap_c = 1'b0;
    k_c   = K_W'(c3 >> 2);
    if (m3_e != '0) begin
      if (sh >= 7'd62 || wide > 96'(K_CAP)) begin
        k_c   = K_CAP;
        cap_c = 1'b1;
      end else begin
        k_c = wide[K_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_k   <= k_c;
      m4_cap <= cap_c;
      for (int i = 0; i < NUM_GRAD; i++) begin
        m4_t[i]   <= T_W'({m3_uu[i][SQ_W-1:2], 1'b0}) + T_W'(m3_uu[i][SQ_W-1:2]);
        m4_sgn[i] <= m3_neg[PAIR_A[i]] ^ m3_neg[PAIR_B[i]];
      end
      m4_zero <= m3_zero;
    end
  end

  // factor 3 u_a u_b - delta, as magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) begin
        if (PAIR_A[i] == PAIR_B[i]) begin
          if (m4_t[i] >= T_ONE) begin
            m5_f[i]   <= F_W'(m4_t[i] - T_ONE);
            m5_neg[i] <= 1'b0;
          end else begin
            m5_f[i]   <= F_W'(T_ONE - m4_t[i]);
            m5_neg[i] <= 1'b1;
          end
        end else begin
          m5_f[i]   <= F_W'(m4_t[i]);
          m5_neg[i] <= m4_sgn[i];
        end
      end
      m5_k    <= m4_k;
      m5_cap  <= m4_cap;
      m5_zero <= m4_zero;
    end
  end

  // k * |f| as four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) begin
        m6_p00[i] <= 64'(m5_k[31:0]) * 64'(m5_f[i][31:0]);
        m6_p01[i] <= 62'(m5_k[31:0]) * 62'(m5_f[i][61:32]);
        m6_p10[i] <= 63'(m5_k[62:32]) * 63'(m5_f[i][31:0]);
        m6_p11[i] <= 61'(m5_k[62:32]) * 61'(m5_f[i][61:32]);
      end
      m6_neg  <= m5_neg;
      m6_cap  <= m5_cap;
      m6_zero <= m5_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) begin
        m7_lo[i]  <= m6_p00[i];
        m7_mid[i] <= 65'(m6_p01[i]) + 65'(m6_p10[i]);
        m7_hi[i]  <= m6_p11[i];
      end
      m7_neg  <= m6_neg;
      m7_cap  <= m6_cap;
      m7_zero <= m6_zero;
    end
  end

  // full product, keep bits 124 down to 72
  always_comb begin
    for (int i = 0; i < NUM_GRAD; i++) begin
      full_c[i] = 125'({m7_hi[i], 64'd0}) + 125'({m7_mid[i], 32'd0}) + 125'(m7_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) m8_mg[i] <= full_c[i][124:72];
      m8_neg  <= m7_neg;
      m8_cap  <= m7_cap;
      m8_zero <= m7_zero;
    end
  end

  // signed contributions out
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_GRAD; i++) begin
        res.contrib[i] <= m8_neg[i] ? CONTRIB_W'(0) - CONTRIB_W'(m8_mg[i])
                                    : CONTRIB_W'(m8_mg[i]);
      end
      res.kcap <= m8_cap;
      res.zero <= m8_zero;
    end
  end

endmodule

// ===== tb/tb_cr3bp_gravity_gradient_unit.sv =====
// Testbench for cr3bp_gravity_gradient_unit: position words in, Jacobian words out,
// each result checked against a bit-exact fixed-point predictor. Needs cr3gg_pkg.
`timescale 1ns / 1ps

module tb_cr3bp_gravity_gradient_unit;
  import cr3gg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = TOTAL_LAT + 20;
  localparam int RAND_ITEMS  = 1230;
  localparam longint ONE_POS = 64'sd536870912;   // 1.0 in Q3.29

  logic  clk, rst;
  logic  pos_valid, pos_ready, grad_valid, grad_ready;
  pos_t  pos;
  grad_t grad;
  bit    quiet;      // no idling on either side while set
  int    cycles;

  cr3bp_gravity_gradient_unit DUT (
    .clk(clk), .rst(rst),
    .pos_valid(pos_valid), .pos_ready(pos_ready), .pos(pos),
    .grad_valid(grad_valid), .grad_ready(grad_ready), .grad(grad)
  );

  // floor(a*b / 2^sh), low 64 bits
  function automatic longint unsigned prod_shift(longint unsigned a, longint unsigned b,
                                                 int unsigned sh);
    bit [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Adds one primary's tidal term to acc; returns 0 when on the primary
  function automatic bit add_body(input longint ofs[3], input longint unsigned mass,
                                  inout longint acc[6], inout bit sat);
    longint unsigned mag[3], unit[3], s, n, root, recip, c3, kq, fm, mg, t;
    bit neg[3];
    int unsigned ex, sh;
    int ia, ib;
    longint f;
    s = 0;
    ex = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = ofs[i] < 0;
      mag[i] = neg[i] ? longint'(-ofs[i]) : ofs[i];
      s += mag[i] * mag[i];       // wraps like the 64-bit hardware sum
    end
    if (s == 0) return 0;
    n = s;
    while (n < (64'd1 << 62)) begin
      n <<= 2;
      ex++;
    end
    root  = int_sqrt(n);
    recip = (64'd1 << 63) / root;
    c3 = prod_shift(prod_shift(prod_shift(recip, recip, 32), recip, 32), mass, 32);
    if (ex == 0) begin
      kq = c3 >> 2;
    end else begin
      sh = 3 * ex - 2;
      if (sh >= 62 || c3 > ((64'd1 << 62) >> sh)) begin
        kq = 64'd1 << 62;
        sat = 1;
      end else begin
        kq = c3 << sh;
      end
    end
    for (int i = 0; i < 3; i++) unit[i] = prod_shift(mag[i], recip, 32 - ex);
    for (int i = 0; i < 6; i++) begin
      ia = PAIR_A[i];
      ib = PAIR_B[i];
      t = 64'd3 * ((unit[ia] * unit[ib]) >> 2);
      f = (neg[ia] != neg[ib]) ? -longint'(t) : longint'(t);
      if (ia == ib) f -= 64'sd1 << 60;
      fm = f < 0 ? longint'(-f) : f;
      mg = prod_shift(kq, fm, 72);
      acc[i] += f < 0 ? -longint'(mg) : longint'(mg);
    end
    return 1;
  endfunction

  // Expected Jacobian word for one position
  function automatic grad_t gradient_of(pos_t p);
    longint e_ofs[3], m_ofs[3], acc[6], v;
    bit sat, ok_e, ok_m;
    logic signed [GRAD_W-1:0] g[6];
    grad_t r;
    acc = '{default: 0};
    sat = 0;
    e_ofs[0] = longint'(p.pos_x) - longint'(EARTH_X);
    m_ofs[0] = longint'(p.pos_x) - longint'(MOON_X);
    e_ofs[1] = longint'(p.pos_y);
    m_ofs[1] = e_ofs[1];
    e_ofs[2] = longint'(p.pos_z);
    m_ofs[2] = e_ofs[2];
    ok_e = add_body(e_ofs, longint'(EARTH_M_Q32), acc, sat);
    ok_m = add_body(m_ofs, longint'(MU_Q32), acc, sat);
    r = '0;
    if (!ok_e || !ok_m) begin
      r.singular = 1;
      return r;
    end
    acc[0] += 64'sd1 << 24;
    acc[3] += 64'sd1 << 24;
    for (int i = 0; i < 6; i++) begin
      v = acc[i];
      if (v > (64'sd1 << 47) - 1) begin v = (64'sd1 << 47) - 1; sat = 1; end
      if (v < -(64'sd1 << 47)) begin v = -(64'sd1 << 47); sat = 1; end
      g[i] = v[GRAD_W-1:0];
    end
    r.grad_xx = g[0]; r.grad_xy = g[1]; r.grad_xz = g[2];
    r.grad_yy = g[3]; r.grad_yz = g[4]; r.grad_zz = g[5];
    r.saturated = sat;
    return r;
  endfunction

  class GradScoreboard;
    grad_t expected_grads[$];
    int    mismatches;

    function void note_position(pos_t p);
      expected_grads.push_back(gradient_of(p));
    endfunction

    function void check_grad(grad_t got);
      grad_t exp_g;
      bit bad;
      if (expected_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected word %h", got);
        return;
      end
      exp_g = expected_grads.pop_front();
      bad = got.grad_xx !== exp_g.grad_xx || got.grad_xy !== exp_g.grad_xy ||
            got.grad_xz !== exp_g.grad_xz || got.grad_yy !== exp_g.grad_yy ||
            got.grad_yz !== exp_g.grad_yz || got.grad_zz !== exp_g.grad_zz ||
            got.saturated !== exp_g.saturated || got.singular !== exp_g.singular;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: grad mismatch");
          $display("  exp xx=%h xy=%h xz=%h yy=%h yz=%h zz=%h sat=%b sng=%b",
                   exp_g.grad_xx, exp_g.grad_xy, exp_g.grad_xz, exp_g.grad_yy,
                   exp_g.grad_yz, exp_g.grad_zz, exp_g.saturated, exp_g.singular);
          $display("  got xx=%h xy=%h xz=%h yy=%h yz=%h zz=%h sat=%b sng=%b",
                   got.grad_xx, got.grad_xy, got.grad_xz, got.grad_yy,
                   got.grad_yz, got.grad_zz, got.saturated, got.singular);
        end
      end
    endfunction
  endclass

  GradScoreboard sb = new();

  // Clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: sample at rising edge, pick stall at falling edge
  initial begin
    grad_ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && grad_valid && grad_ready) sb.check_grad(grad);
      @(negedge clk);
      grad_ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  // Offers one position word and waits until it is taken
  task automatic send_pos(pos_t p);
    while (!quiet && $urandom_range(99) < 6) begin
      pos_valid <= 0;
      @(negedge clk);
    end
    pos_valid <= 1;
    pos <= p;
    do @(posedge clk); while (!pos_ready);
    sb.note_position(p);
    @(negedge clk);
  endtask

  function automatic pos_t make_pos(longint x, longint y, longint z);
    pos_t p;
    p.pos_x = x[31:0];
    p.pos_y = y[31:0];
    p.pos_z = z[31:0];
    return p;
  endfunction

  // Random position: half physical range, a quarter near a primary, a quarter raw bits
  function automatic pos_t rand_pos();
    int kind;
    longint cx, span;
    pos_t p;
    kind = $urandom_range(99);
    if (kind < 50) begin
      p = make_pos($urandom_range(2 * 805306368) - 805306368,
                   $urandom_range(2 * 805306368) - 805306368,
                   $urandom_range(2 * 268435456) - 268435456);
      if ($urandom_range(3) == 0) p.pos_z = '0;
    end else if (kind < 75) begin
      cx = $urandom_range(1) ? longint'(EARTH_X) : longint'(MOON_X);
      span = longint'(1) << $urandom_range(24);
      p = make_pos(cx + $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span);
      if ($urandom_range(4) == 0) p.pos_y = '0;
      if ($urandom_range(4) == 0) p.pos_z = '0;
    end else begin
      p = make_pos($urandom, $urandom, $urandom);
    end
    return p;
  endfunction

  // Stimulus
  initial begin
    pos_t directed[$];
    rst = 1;
    pos_valid = 0;
    pos = '0;
    quiet = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    directed = '{
      make_pos(0, 0, 0),
      make_pos(EARTH_X, 0, 0),                       // on the Earth
      make_pos(MOON_X, 0, 0),                        // on the Moon
      make_pos(longint'(EARTH_X) + 1, 0, 0),         // inverse cube capped
      make_pos(longint'(MOON_X) - 1, 0, 0),
      make_pos(MOON_X, 1, 0),
      make_pos(MOON_X, 0, -1),
      make_pos(longint'(MOON_X) + 4096, -4096, 4096),
      make_pos(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
      make_pos(32'h80000000, 32'h80000000, 32'h80000000),
      make_pos(32'h7fffffff, 32'h80000000, 0),
      make_pos(32'h80000000, 32'h7fffffff, 32'h80000000),
      make_pos(32'hffffffff, 32'hffffffff, 32'hffffffff),
      make_pos(ONE_POS, 0, 0),
      make_pos(-ONE_POS, 0, 0),
      make_pos(0, ONE_POS, 0),
      make_pos(0, 0, ONE_POS),
      make_pos(448857325, 0, 0),                     // near L1
      make_pos(623000000, 0, 0),                     // near L2
      make_pos(262000000, 465000000, 0),             // near L4
      make_pos(ONE_POS / 2, -ONE_POS / 3, ONE_POS / 5),
      make_pos(32'h55555555, 32'haaaaaaaa, 32'h55555555)
    };
    foreach (directed[i]) send_pos(directed[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= 300 && i < 550);
      if (i == 700) begin
        // hold off until the pipeline has fully drained
        pos_valid <= 0;
        while (sb.expected_grads.size() != 0) @(negedge clk);
      end
      send_pos(rand_pos());
    end
    pos_valid <= 0;

    while (sb.expected_grads.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_grads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
